### rtl/core/gsb_pkg.sv
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared types and constants for the graph store with shortest-path search.
// ----------------------------------------------------------------------------
package gsb_pkg;

  localparam int NODES = 64;
  localparam int IDW   = $clog2(NODES);
  localparam int CNTW  = IDW + 1;

  typedef enum logic [2:0] {
    FN_ADD_NODE = 3'd0,
    FN_DEL_NODE = 3'd1,
    FN_ADD_EDGE = 3'd2,
    FN_DEL_EDGE = 3'd3,
    FN_PATH     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OP_ADD_NODE,
    OP_DEL_NODE,
    OP_ADD_EDGE,
    OP_DEL_EDGE,
    OP_PATH,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_NODE    = 2'd0,
    ST_NOPATH  = 2'd1,
    ST_DONE    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    op_t            op;
    logic [IDW-1:0] a;
    logic [IDW-1:0] b;
  } cmd_t;

  // one queue port: valid flag plus command
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmd_port_t;

endpackage

### rtl/core/gsb_front.sv
// ----------------------------------------------------------------------------
// gsb_front
// Input handshake and decode of the selector into a command for the queue.
// ----------------------------------------------------------------------------
module gsb_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // first_id, second_id
  input  logic [2:0]            in_tuser,   // func
  input  logic                  q_full,
  output gsb_pkg::cmd_port_t    push
);

  gsb_pkg::op_t op;

  always_comb begin
    unique case (in_tuser)
      gsb_pkg::FN_ADD_NODE: op = gsb_pkg::OP_ADD_NODE;
      gsb_pkg::FN_DEL_NODE: op = gsb_pkg::OP_DEL_NODE;
      gsb_pkg::FN_ADD_EDGE: op = gsb_pkg::OP_ADD_EDGE;
      gsb_pkg::FN_DEL_EDGE: op = gsb_pkg::OP_DEL_EDGE;
      gsb_pkg::FN_PATH:     op = gsb_pkg::OP_PATH;
      default:              op = gsb_pkg::OP_NONE;
    endcase
  end

  assign in_tready    = !q_full;
  assign push.vld     = in_tvalid && !q_full;
  assign push.cmd.op  = op;
  assign push.cmd.a   = in_tdata[gsb_pkg::IDW-1:0];
  assign push.cmd.b   = in_tdata[2*gsb_pkg::IDW-1:gsb_pkg::IDW];

endmodule

### rtl/core/gsb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gsb_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module gsb_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  gsb_pkg::cmd_port_t  push,
  output logic                full,
  output gsb_pkg::cmd_port_t  head,
  input  logic                pop
);

  gsb_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_pop;

  assign full     = (count_r == 2'd2);
  assign head.vld = (count_r != 2'd0);
  assign head.cmd = mem_r[rd_ptr_r];
  assign do_pop   = pop && head.vld;

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.vld) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)   rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push.vld) - 2'(do_pop);
    end
  end

endmodule

### rtl/core/gsb_back.sv
// ----------------------------------------------------------------------------
// gsb_back
// Graph engine: adjacency memory, updates, breadth-first search, path output.
// ----------------------------------------------------------------------------
module gsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gsb_pkg::cmd_port_t  head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // path_node
  output logic [1:0]          out_tuser,   // status
  output logic                out_tlast
);

  localparam int N  = gsb_pkg::NODES;
  localparam int IW = gsb_pkg::IDW;
  localparam int CW = gsb_pkg::CNTW;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ROW_RD   = 13'b0000000000010,
    S_ROW_WR   = 13'b0000000000100,
    S_COL_RD   = 13'b0000000001000,
    S_COL_WR   = 13'b0000000010000,
    S_BFS_DEQ  = 13'b0000000100000,
    S_BFS_ROW  = 13'b0000001000000,
    S_BFS_SCAN = 13'b0000010000000,
    S_WALK     = 13'b0000100000000,
    S_WALK_RD  = 13'b0001000000000,
    S_EMIT_RD  = 13'b0010000000000,
    S_EMIT     = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  gsb_pkg::status_t  status_r, status_nxt;
  gsb_pkg::cmd_t     cmd_r;
  logic              second_r;
  logic [N-1:0]      present_r;
  logic [N-1:0]      row_vld_r;
  logic [N-1:0]      seen_r;
  logic [CW-1:0]     head_r, tail_r;
  logic [IW-1:0]     u_r, v_r, node_r, ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              out_vld_r, out_last_r;
  logic [IW-1:0]     out_node_r;
  gsb_pkg::status_t  out_status_r;

  logic [N-1:0]      adj_mem [N];
  logic [IW-1:0]     par_mem [N];
  logic [IW-1:0]     que_mem [N];
  logic [IW-1:0]     stk_mem [N];
  logic [N-1:0]      adj_rd_r;
  logic              adj_rvld_r;
  logic [IW-1:0]     par_rd_r, que_rd_r, stk_rd_r;

  logic              can_put, put, found, both_in;
  logic [N-1:0]      row;
  logic [IW-1:0]     edge_x, edge_y;
  logic              adj_ren, adj_we;
  logic [IW-1:0]     adj_raddr, adj_waddr;
  logic [N-1:0]      adj_wdata;
  logic              que_we;
  logic [IW-1:0]     que_waddr, que_wdata;

  assign can_put = !out_vld_r || out_tready;
  assign pop     = (state_r == S_IDLE) && head.vld;
  assign row     = adj_rvld_r ? adj_rd_r : '0;
  assign edge_x  = second_r ? cmd_r.b : cmd_r.a;
  assign edge_y  = second_r ? cmd_r.a : cmd_r.b;
  assign found   = row[v_r] && !seen_r[v_r];
  assign both_in = present_r[head.cmd.a] && present_r[head.cmd.b];
  assign put     = ((state_r == S_EMIT) || (state_r == S_DONE)) && can_put;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    adj_ren    = 1'b0;
    adj_raddr  = edge_x;
    adj_we     = 1'b0;
    adj_waddr  = edge_x;
    adj_wdata  = row;
    que_we     = 1'b0;
    que_waddr  = tail_r[IW-1:0];
    que_wdata  = v_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.vld) begin
          state_nxt = S_DONE;
          case (head.cmd.op)
            gsb_pkg::OP_ADD_NODE:
              status_nxt = present_r[head.cmd.a] ? gsb_pkg::ST_IGNORED : gsb_pkg::ST_DONE;
            gsb_pkg::OP_DEL_NODE: begin
              if (present_r[head.cmd.a]) begin
                status_nxt = gsb_pkg::ST_DONE;
                state_nxt  = S_COL_RD;
              end else begin
                status_nxt = gsb_pkg::ST_IGNORED;
              end
            end
            gsb_pkg::OP_ADD_EDGE: begin
              if (both_in) begin
                status_nxt = gsb_pkg::ST_DONE;
                state_nxt  = S_ROW_RD;
              end else begin
                status_nxt = gsb_pkg::ST_IGNORED;
              end
            end
            gsb_pkg::OP_DEL_EDGE: begin
              status_nxt = gsb_pkg::ST_DONE;
              state_nxt  = S_ROW_RD;
            end
            gsb_pkg::OP_PATH: begin
              status_nxt = gsb_pkg::ST_NOPATH;
              if (both_in) begin
                state_nxt = S_BFS_DEQ;
                que_we    = 1'b1;
                que_waddr = '0;
                que_wdata = head.cmd.a;
              end
            end
            default: status_nxt = gsb_pkg::ST_IGNORED;
          endcase
        end
      end
      S_ROW_RD: begin
        adj_ren   = 1'b1;
        state_nxt = S_ROW_WR;
      end
      S_ROW_WR: begin
        adj_we    = 1'b1;
        adj_wdata = (cmd_r.op == gsb_pkg::OP_ADD_EDGE) ? (row | (N'(1) << edge_y))
                                                       : (row & ~(N'(1) << edge_y));
        state_nxt = second_r ? S_DONE : S_ROW_RD;
      end
      S_COL_RD: begin
        adj_ren   = 1'b1;
        adj_raddr = v_r;
        state_nxt = S_COL_WR;
      end
      S_COL_WR: begin
        adj_we    = 1'b1;
        adj_waddr = v_r;
        adj_wdata = row & ~(N'(1) << cmd_r.a);
        state_nxt = (v_r == IW'(N-1)) ? S_DONE : S_COL_RD;
      end
      S_BFS_DEQ: begin
        if (head_r == tail_r) begin
          state_nxt = seen_r[cmd_r.b] ? S_WALK : S_DONE;
        end else begin
          state_nxt = S_BFS_ROW;
        end
      end
      S_BFS_ROW: begin
        adj_ren   = 1'b1;
        adj_raddr = que_rd_r;
        state_nxt = S_BFS_SCAN;
      end
      S_BFS_SCAN: begin
        que_we = found;
        if (v_r == IW'(N-1)) state_nxt = S_BFS_DEQ;
      end
      S_WALK:    state_nxt = (node_r == cmd_r.a) ? S_EMIT_RD : S_WALK_RD;
      S_WALK_RD: state_nxt = S_WALK;
      S_EMIT_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (can_put) state_nxt = (ptr_r == '0) ? S_IDLE : S_EMIT_RD;
      end
      S_DONE: begin
        if (can_put) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_ren) begin
      adj_rd_r   <= adj_mem[adj_raddr];
      adj_rvld_r <= row_vld_r[adj_raddr];
    end
    if (que_we) que_mem[que_waddr] <= que_wdata;
    if (state_r == S_BFS_DEQ) que_rd_r <= que_mem[head_r[IW-1:0]];
    if ((state_r == S_BFS_SCAN) && found) par_mem[v_r] <= u_r;
    if (state_r == S_WALK) begin
      stk_mem[cnt_r[IW-1:0]] <= node_r;
      par_rd_r               <= par_mem[node_r];
    end
    if (state_r == S_EMIT_RD) stk_rd_r <= stk_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      status_r  <= gsb_pkg::ST_IGNORED;
      present_r <= '0;
      row_vld_r <= '0;
      seen_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (out_vld_r && out_tready) out_vld_r <= 1'b0;
      if (put) out_vld_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (head.vld) begin
            case (head.cmd.op)
              gsb_pkg::OP_ADD_NODE: begin
                if (!present_r[head.cmd.a]) begin
                  present_r[head.cmd.a] <= 1'b1;
                  row_vld_r[head.cmd.a] <= 1'b0;
                end
              end
              gsb_pkg::OP_DEL_NODE: begin
                if (present_r[head.cmd.a]) begin
                  present_r[head.cmd.a] <= 1'b0;
                  row_vld_r[head.cmd.a] <= 1'b0;
                end
              end
              gsb_pkg::OP_PATH: begin
                if (both_in) seen_r <= N'(1) << head.cmd.a;
              end
              default: ;
            endcase
          end
        end
        S_ROW_WR:   row_vld_r[edge_x] <= 1'b1;
        S_COL_WR:   row_vld_r[v_r] <= 1'b1;
        S_BFS_SCAN: begin
          if (found) seen_r[v_r] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r    <= head.cmd;
        second_r <= 1'b0;
        v_r      <= '0;
        head_r   <= '0;
        tail_r   <= CW'(1);
      end
      S_ROW_WR:   second_r <= 1'b1;
      S_COL_WR:   v_r <= v_r + IW'(1);
      S_BFS_DEQ: begin
        if (head_r != tail_r) head_r <= head_r + CW'(1);
        node_r <= cmd_r.b;
        cnt_r  <= '0;
      end
      S_BFS_ROW: begin
        u_r <= que_rd_r;
        v_r <= '0;
      end
      S_BFS_SCAN: begin
        if (found) tail_r <= tail_r + CW'(1);
        v_r <= v_r + IW'(1);
      end
      S_WALK: begin
        cnt_r <= cnt_r + CW'(1);
        ptr_r <= cnt_r[IW-1:0];
      end
      S_WALK_RD: node_r <= par_rd_r;
      S_EMIT: begin
        if (can_put) ptr_r <= ptr_r - IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (put) begin
      if (state_r == S_EMIT) begin
        out_node_r   <= stk_rd_r;
        out_status_r <= gsb_pkg::ST_NODE;
        out_last_r   <= (ptr_r == '0);
      end else begin
        out_node_r   <= '0;
        out_status_r <= status_r;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8-IW){1'b0}}, out_node_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/graph_store_bfs_shortest_path.sv
// ----------------------------------------------------------------------------
// graph_store_bfs_shortest_path
// Undirected graph store with breadth-first shortest-path queries.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                       tuser       tlast
//  in_      in   [5:0] first_id [11:6] 2nd   func [2:0]  -
//  out_     out  [5:0] path_node             status      last
//
// remove node sweeps the adjacency column, reading and rewriting each row.
// path query: a breadth-first search scans each reached node's row, one adjacency bit a cycle,
// then walks back along the parents and emits the path nodes.
// reset leaves the graph empty; a two-entry queue decouples input from the engine.
// out_ stalls hold the engine; the input still takes items until the queue fills.
module graph_store_bfs_shortest_path (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // first_id, second_id
  input  logic [2:0]  in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // path_node
  output logic [1:0]  out_tuser,   // status
  output logic        out_tlast
);

  gsb_pkg::cmd_port_t push, q_head;
  logic               q_full, q_pop;

  gsb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push)
  );

  gsb_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  gsb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
